FILE: src/lvpc_pkg.sv
// shared types, constants and helpers for the last-value predictor
package lvpc_pkg;

    // table geometry
    localparam int INDEX_BITS     = 16;
    localparam int INFLIGHT_DEPTH = 256;
    localparam int SLOT_BITS      = $clog2(INFLIGHT_DEPTH);
    localparam int CLR_BITS       = (INDEX_BITS > SLOT_BITS) ? INDEX_BITS : SLOT_BITS;

    // field widths
    localparam int COUNT_BITS = 16;
    localparam int VALUE_BITS = 64;
    localparam int SEQ_BITS   = 64;
    localparam int ADDR_BITS  = 32;
    localparam int PIECE_BITS = 8;
    localparam int FUNC_BITS  = 2;

    // configuration port
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam logic [PADDR_BITS-3:0] REG_CONF_MAX = '0;

    // constants
    localparam logic [VALUE_BITS-1:0] NO_VALUE   = 64'h0000_0000_dead_beef;
    localparam logic [COUNT_BITS-1:0] CONF_RESET = 16'd10000;

    // item kinds
    localparam logic [FUNC_BITS-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_RECORD = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_TRAIN  = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_NOP    = 2'd3;

    // prediction table entry
    typedef struct packed {
        logic                  valid;
        logic                  confident;
        logic [COUNT_BITS-1:0] count;
        logic [VALUE_BITS-1:0] value;
    } pred_entry_t;

    // in-flight table entry
    typedef struct packed {
        logic                 valid;
        logic [SEQ_BITS-1:0]  seq;
        logic [ADDR_BITS-1:0] addr;
    } slot_entry_t;

    // xor-fold of the two low index-wide slices of the address
    function automatic logic [INDEX_BITS-1:0] fold_index(input logic [ADDR_BITS-1:0] addr);
        logic [63:0] a;
        a = 64'(addr);
        return a[INDEX_BITS-1:0] ^ a[2*INDEX_BITS-1:INDEX_BITS];
    endfunction

endpackage

FILE: src/lvpc_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module lvpc_ram #(
    parameter int ADDR_W = 4,
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/lvpc_cfg.sv
// apb register block holding the confidence ceiling
module lvpc_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lvpc_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [lvpc_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [lvpc_pkg::PDATA_BITS-1:0]    prdata,
    output logic                               pready,
    output logic [lvpc_pkg::COUNT_BITS-1:0]    conf_max
);

    logic [lvpc_pkg::COUNT_BITS-1:0] conf_max_reg;
    logic [lvpc_pkg::COUNT_BITS-1:0] conf_max_next;
    logic                            sel_conf;

    assign sel_conf = (paddr[lvpc_pkg::PADDR_BITS-1:2] == lvpc_pkg::REG_CONF_MAX);

    // write on the access phase
    always_comb
    begin
        conf_max_next = conf_max_reg;
        if (psel && penable && pwrite && sel_conf)
        begin
            conf_max_next = pwdata[lvpc_pkg::COUNT_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_max_reg <= lvpc_pkg::CONF_RESET;
        end
        else
        begin
            conf_max_reg <= conf_max_next;
        end
    end

    // read back
    assign prdata   = sel_conf ? lvpc_pkg::PDATA_BITS'(conf_max_reg) : '0;
    assign pready   = 1'b1;
    assign conf_max = conf_max_reg;

endmodule

FILE: src/lvpc_update.sv
// counter and confidence update of one prediction entry on training
module lvpc_update (
    input  lvpc_pkg::pred_entry_t             entry_in,
    input  logic [lvpc_pkg::VALUE_BITS-1:0]   value,
    input  logic [lvpc_pkg::COUNT_BITS-1:0]   conf_max,
    output lvpc_pkg::pred_entry_t             entry_out
);

    logic                            match;
    logic [lvpc_pkg::COUNT_BITS:0]   count_inc;
    logic [lvpc_pkg::COUNT_BITS-1:0] count_dec;

    // an empty entry never matches
    assign match     = entry_in.valid && (entry_in.value == value);
    assign count_inc = {1'b0, entry_in.count} + 1'b1;
    assign count_dec = (entry_in.count != '0) ? entry_in.count - 1'b1 : '0;

    always_comb
    begin
        entry_out       = entry_in;
        entry_out.valid = 1'b1;
        entry_out.value = value;
        if (match)
        begin
            // count up, clamp at the ceiling and set confidence there
            if (count_inc >= {1'b0, conf_max})
            begin
                entry_out.count     = conf_max;
                entry_out.confident = 1'b1;
            end
            else
            begin
                entry_out.count = count_inc[lvpc_pkg::COUNT_BITS-1:0];
            end
        end
        else
        begin
            // count down, saturate at zero and drop confidence there
            entry_out.count = count_dec;
            if (count_dec == '0)
            begin
                entry_out.confident = 1'b0;
            end
        end
    end

endmodule

FILE: src/last_value_predictor_confidence.sv
// last-value predictor top level: control sequencer around two table memories
// lookup, record, train miss, no-op: both tables are read on transfer, result loaded in S_LOOK;
// a train that updates the prediction table goes on to S_TRAIN to write back and load the result
// one item at a time: a new transfer is taken only in S_IDLE, once the last result is loaded;
// the wait is set by the prediction read-modify-write, the in-flight read and output stalls
// after reset both memories are cleared one entry a cycle, all 2^16 indices, before in_ready rises
module last_value_predictor_confidence (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [lvpc_pkg::FUNC_BITS-1:0]     func,
    input  logic [lvpc_pkg::SEQ_BITS-1:0]      sequence_number,
    input  logic [lvpc_pkg::ADDR_BITS-1:0]     instr_address,
    input  logic [lvpc_pkg::PIECE_BITS-1:0]    piece_index,
    input  logic                               is_eligible,
    input  logic                               value_class,
    input  logic [lvpc_pkg::VALUE_BITS-1:0]    result_value,
    // output channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               predict_hit,
    output logic [lvpc_pkg::VALUE_BITS-1:0]    pred_value,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lvpc_pkg::PADDR_BITS-1:0]    paddr,
    input  logic [lvpc_pkg::PDATA_BITS-1:0]    pwdata,
    output logic [lvpc_pkg::PDATA_BITS-1:0]    prdata,
    output logic                               pready
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_LOOK  = 4'b0100,
        S_TRAIN = 4'b1000
    } state_t;

    localparam int IB = lvpc_pkg::INDEX_BITS;
    localparam int SB = lvpc_pkg::SLOT_BITS;
    localparam int CB = lvpc_pkg::CLR_BITS;

    state_t state_reg, state_next;
    logic [CB-1:0] clr_cnt_reg, clr_cnt_next;

    // latched item
    logic [lvpc_pkg::FUNC_BITS-1:0]  func_reg;
    logic [lvpc_pkg::SEQ_BITS-1:0]   seq_reg;
    logic [lvpc_pkg::ADDR_BITS-1:0]  addr_reg;
    logic [lvpc_pkg::PIECE_BITS-1:0] piece_reg;
    logic                            elig_reg;
    logic                            vclass_reg;
    logic [lvpc_pkg::VALUE_BITS-1:0] value_reg;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic                            hit_reg;
    logic [lvpc_pkg::VALUE_BITS-1:0] pred_reg;
    logic                            out_load;
    logic                            out_hit;
    logic [lvpc_pkg::VALUE_BITS-1:0] out_value;
    logic                            out_free;

    // memory ports
    logic                   pm_we, pm_re;
    logic [IB-1:0]          pm_waddr, pm_raddr;
    lvpc_pkg::pred_entry_t  pm_wdata, pm_rdata, pm_upd;
    logic                   sm_we, sm_re;
    logic [SB-1:0]          sm_waddr, sm_raddr;
    lvpc_pkg::slot_entry_t  sm_wdata, sm_rdata;

    logic [lvpc_pkg::COUNT_BITS-1:0] conf_max;
    logic                            in_xfer;
    logic                            rec_taken;
    logic                            train_hit;
    logic                            look_hit;

    // configuration registers
    lvpc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .conf_max (conf_max)
    );

    // prediction table
    lvpc_ram #(
        .ADDR_W (IB),
        .DATA_W ($bits(lvpc_pkg::pred_entry_t))
    ) u_pred_mem (
        .clk   (clk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .re    (pm_re),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    // in-flight table
    lvpc_ram #(
        .ADDR_W (SB),
        .DATA_W ($bits(lvpc_pkg::slot_entry_t))
    ) u_slot_mem (
        .clk   (clk),
        .we    (sm_we),
        .waddr (sm_waddr),
        .wdata (sm_wdata),
        .re    (sm_re),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    // entry update on training
    lvpc_update u_update (
        .entry_in  (pm_rdata),
        .value     (value_reg),
        .conf_max  (conf_max),
        .entry_out (pm_upd)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // decode of the latched item and its read data
    assign rec_taken = vclass_reg && elig_reg && (piece_reg == '0);
    assign train_hit = sm_rdata.valid && (sm_rdata.seq == seq_reg);
    assign look_hit  = pm_rdata.valid && pm_rdata.confident && (piece_reg == '0);

    // sequencer and memory control
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        pm_we        = 1'b0;
        pm_waddr     = clr_cnt_reg[IB-1:0];
        pm_wdata     = '0;
        pm_re        = 1'b0;
        pm_raddr     = lvpc_pkg::fold_index(instr_address);
        sm_we        = 1'b0;
        sm_waddr     = clr_cnt_reg[SB-1:0];
        sm_wdata     = '0;
        sm_re        = 1'b0;
        sm_raddr     = sequence_number[SB-1:0];
        out_load     = 1'b0;
        out_hit      = 1'b0;
        out_value    = '0;
        case (state_reg)
            S_CLEAR:
            begin
                // sweep both tables to zero
                pm_we        = 1'b1;
                sm_we        = 1'b1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                // read both tables for the new item
                if (in_xfer)
                begin
                    pm_re      = 1'b1;
                    sm_re      = 1'b1;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                sm_waddr = seq_reg[SB-1:0];
                if (func_reg == lvpc_pkg::FUNC_TRAIN && train_hit
                    && value_reg != lvpc_pkg::NO_VALUE)
                begin
                    // free the slot and read the entry to train
                    sm_we          = 1'b1;
                    sm_wdata       = sm_rdata;
                    sm_wdata.valid = 1'b0;
                    pm_re          = 1'b1;
                    pm_raddr       = lvpc_pkg::fold_index(sm_rdata.addr);
                    state_next     = S_TRAIN;
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    case (func_reg)
                        lvpc_pkg::FUNC_LOOKUP:
                        begin
                            out_hit   = look_hit;
                            out_value = look_hit ? pm_rdata.value : '0;
                        end
                        lvpc_pkg::FUNC_RECORD:
                        begin
                            sm_we         = rec_taken;
                            sm_wdata.valid = 1'b1;
                            sm_wdata.seq  = seq_reg;
                            sm_wdata.addr = addr_reg;
                        end
                        lvpc_pkg::FUNC_TRAIN:
                        begin
                            // hit without a value only frees the slot
                            sm_we          = train_hit;
                            sm_wdata       = sm_rdata;
                            sm_wdata.valid = 1'b0;
                        end
                        default:
                        begin
                            out_hit = 1'b0;
                        end
                    endcase
                end
            end
            S_TRAIN:
            begin
                // write back the trained entry, slot data holds until the next read
                pm_waddr = lvpc_pkg::fold_index(sm_rdata.addr);
                pm_wdata = pm_upd;
                if (out_free)
                begin
                    pm_we      = 1'b1;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // output register next value
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg   <= func;
            seq_reg    <= sequence_number;
            addr_reg   <= instr_address;
            piece_reg  <= piece_index;
            elig_reg   <= is_eligible;
            vclass_reg <= value_class;
            value_reg  <= result_value;
        end
        if (out_load)
        begin
            hit_reg  <= out_hit;
            pred_reg <= out_value;
        end
    end

    assign out_valid   = out_valid_reg;
    assign predict_hit = hit_reg;
    assign pred_value  = pred_reg;

endmodule

FILE: src/lvpc_checker.sv
// port-level checker for the last-value predictor, bound to the top level
module lvpc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic                            predict_hit,
    input logic [lvpc_pkg::VALUE_BITS-1:0] pred_value
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(predict_hit) && $stable(pred_value))
        else $error("result payload changed while stalled");

    // a miss always carries a zero value
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !predict_hit |-> pred_value == '0)
        else $error("nonzero value on a miss");

    // one item at a time: busy right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");

endmodule

bind last_value_predictor_confidence lvpc_checker u_lvpc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .predict_hit (predict_hit),
    .pred_value  (pred_value)
);
